[sv/hts_pkg.sv]
// Shared types, constants and helper functions of the HTML to text stripper.
`default_nettype none

package hts_pkg;

  typedef enum logic [3:0] {
    MODE_TEXT,
    MODE_TAG,
    MODE_TAG_DQ,
    MODE_TAG_DQ_ESC,
    MODE_TAG_SQ,
    MODE_TAG_SQ_ESC,
    MODE_COMMENT,
    MODE_COMMENT_END,
    MODE_SCRIPT,
    MODE_STYLE,
    MODE_CDATA
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SKIP,
    ST_ENT,
    ST_UTF
  } state_t;

  typedef struct packed {
    logic accept;
    logic decide;
    logic drop;
    logic skip;
    logic ent;
    logic utf;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic one;
    logic full;
    logic undecided;
    logic more;
    logic ent_num;
    logic can_emit;
    logic hold_pend;
    logic out_free;
    logic skip_last;
    logic ent_good;
    logic utf_last;
  } sts_t;

  localparam int SKIP_W      = 5;
  localparam int RES_CNT_W   = 5;
  localparam int MAX_RESULTS = 16;
  localparam int CP_W        = 21;
  localparam int NUM_W       = 25;

  localparam logic [NUM_W-1:0] CP_MAX  = 25'h010FFFF;
  localparam logic [CP_W-1:0]  SUR_LO  = 21'h00D800;
  localparam logic [CP_W-1:0]  SUR_HI  = 21'h00DFFF;

  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_X    = 8'h78;
  localparam logic [7:0] CH_DQ   = 8'h22;
  localparam logic [7:0] CH_SQ   = 8'h27;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_DASH = 8'h2D;
  localparam logic [7:0] CH_RBR  = 8'h5D;
  localparam logic [7:0] CH_BANG = 8'h21;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NL   = 8'h0A;
  localparam logic [7:0] CH_TAB  = 8'h09;
  localparam logic [7:0] CH_CR   = 8'h0D;

  localparam logic [47:0] PAT_SCRIPT     = "script";
  localparam logic [39:0] PAT_STYLE      = "style";
  localparam logic [63:0] PAT_CDATA      = "![cdata[";
  localparam logic [79:0] PAT_BQ         = "blockquote";
  localparam logic [95:0] PAT_BQ_END     = "/blockquote>";
  localparam logic [71:0] PAT_SCRIPT_END = "</script>";
  localparam logic [63:0] PAT_STYLE_END  = "</style>";
  localparam logic [23:0] PAT_CDATA_END  = "]]>";

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_CR) || (c == CH_NL);
  endfunction

  function automatic logic [7:0] fold(input logic [7:0] c);
    return ((c >= 8'h41) && (c <= 8'h5A)) ? c + 8'd32 : c;
  endfunction

  // {valid, value}
  function automatic logic [4:0] digit_val(input logic [7:0] c, input logic hex);
    logic [4:0] r;
    r = 5'd0;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (hex && (c >= 8'h61) && (c <= 8'h66)) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (hex && (c >= 8'h41) && (c <= 8'h46)) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // Encoded length minus one
  function automatic logic [1:0] utf8_len(input logic [CP_W-1:0] v);
    logic [1:0] r;
    if (v < 21'h80) begin
      r = 2'd0;
    end else if (v < 21'h800) begin
      r = 2'd1;
    end else if (v < 21'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  function automatic logic [7:0] utf8_byte(input logic [CP_W-1:0] v, input logic [1:0] lm1,
                                           input logic [1:0] idx);
    logic [7:0] r;
    r = v[7:0];
    case (lm1)
      2'd0: r = v[7:0];
      2'd1: r = (idx == 2'd0) ? {3'b110, v[10:6]} : {2'b10, v[5:0]};
      2'd2: begin
        case (idx)
          2'd0:    r = {4'b1110, v[15:12]};
          2'd1:    r = {2'b10, v[11:6]};
          default: r = {2'b10, v[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0:    r = {5'b11110, v[20:18]};
          2'd1:    r = {2'b10, v[17:12]};
          2'd2:    r = {2'b10, v[11:6]};
          default: r = {2'b10, v[5:0]};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/hts_in_if.sv]
// Input channel of the stripper: one HTML source byte per item.
`default_nettype none

interface hts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

`default_nettype wire

[sv/hts_out_if.sv]
// Result channel of the stripper: one text byte per item with an end-of-step flag.
`default_nettype none

interface hts_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_last, output ready);
endinterface

`default_nettype wire

[sv/hts_ctrl.sv]
// Sequencing state machine of the stripper.
`default_nettype none

module hts_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire hts_pkg::sts_t sts,
  output hts_pkg::cmd_t      cmd
);

  hts_pkg::state_t state_r;
  hts_pkg::state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hts_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hts_pkg::ST_IDLE: begin
        if (in_valid && in_ready) begin
          state_nxt = hts_pkg::ST_DECIDE;
        end
      end
      hts_pkg::ST_DECIDE: begin
        if (sts.empty) begin
          state_nxt = hts_pkg::ST_IDLE;
        end else if (sts.undecided) begin
          if (!sts.full) begin
            state_nxt = hts_pkg::ST_IDLE;
          end
        end else if (sts.can_emit) begin
          if (sts.ent_num) begin
            state_nxt = hts_pkg::ST_ENT;
          end else if (sts.more) begin
            state_nxt = hts_pkg::ST_SKIP;
          end else if (sts.one) begin
            state_nxt = hts_pkg::ST_IDLE;
          end
        end
      end
      hts_pkg::ST_SKIP: begin
        if (sts.skip_last) begin
          state_nxt = sts.one ? hts_pkg::ST_IDLE : hts_pkg::ST_DECIDE;
        end
      end
      hts_pkg::ST_ENT: begin
        if (sts.skip_last) begin
          if (sts.ent_good) begin
            state_nxt = hts_pkg::ST_UTF;
          end else begin
            state_nxt = sts.one ? hts_pkg::ST_IDLE : hts_pkg::ST_DECIDE;
          end
        end
      end
      hts_pkg::ST_UTF: begin
        if (sts.can_emit && sts.utf_last) begin
          state_nxt = sts.empty ? hts_pkg::ST_IDLE : hts_pkg::ST_DECIDE;
        end
      end
      default: state_nxt = hts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      hts_pkg::ST_IDLE: begin
        in_ready   = !sts.hold_pend || sts.out_free;
        cmd.accept = in_valid && in_ready;
        cmd.flush  = sts.hold_pend && sts.out_free;
      end
      hts_pkg::ST_DECIDE: begin
        if (!sts.empty) begin
          if (sts.undecided) begin
            cmd.drop = sts.full;
          end else begin
            cmd.decide = sts.can_emit;
          end
        end
      end
      hts_pkg::ST_SKIP: cmd.skip = 1'b1;
      hts_pkg::ST_ENT:  cmd.ent  = 1'b1;
      hts_pkg::ST_UTF:  cmd.utf  = sts.can_emit;
      default:          cmd      = '0;
    endcase
  end

endmodule

`default_nettype wire

[sv/hts_dp.sv]
// Datapath of the stripper: lookahead register, parse state, entity unit and result staging.
`default_nettype none

module hts_dp #(
  parameter int DEPTH = 16,
  parameter int EML   = 10,
  parameter int QDB   = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire hts_pkg::cmd_t cmd,
  output hts_pkg::sts_t      sts,
  input  wire logic [7:0]    in_byte,
  input  wire logic          cfg_we,
  input  wire logic          cfg_wdata,
  input  wire logic          out_ready,
  output logic               out_valid,
  output logic [7:0]         out_byte,
  output logic               out_last
);

  localparam int CNT_W = $clog2(DEPTH + 2);
  localparam int ELIM  = (EML < DEPTH) ? EML : DEPTH;
  localparam int SW    = hts_pkg::SKIP_W;

  logic [7:0]                    lab_r [DEPTH+1];
  logic [CNT_W-1:0]              count_r;
  hts_pkg::mode_t                mode_r;
  logic [QDB-1:0]                depth_r;
  logic [7:0]                    last_r;
  logic                          any_r;
  logic                          sq_r;
  logic [SW-1:0]                 skip_r;
  logic [1:0]                    ent_pre_r;
  logic                          ent_hex_r;
  logic                          ent_bad_r;
  logic [hts_pkg::CP_W-1:0]      ent_val_r;
  logic [1:0]                    utf_idx_r;
  logic                          hold_v_r;
  logic [7:0]                    hold_b_r;
  logic [hts_pkg::RES_CNT_W-1:0] res_cnt_r;
  logic                          out_v_r;
  logic [7:0]                    out_b_r;
  logic                          out_l_r;

  logic [7:0]        h;
  logic [CNT_W-1:0]  rem;
  logic              depth_zero;
  logic              m_cm, m_sc, m_st, m_cd, m_bo, m_bc, t_found;
  logic              e_sc_ok, e_st_ok, e_cd_ok;
  logic              n_hit, n_ws, n_hex, n_num, n_bad0;
  logic [SW-1:0]     n_f;
  logic              dec_undec, dec_emit, dec_space, dec_inc, dec_dec, dec_ent;
  logic [SW-1:0]     dec_adv;
  hts_pkg::mode_t    dec_mode;
  logic              space_ok, emit_req, emit_fire, store_ok, do_shift, out_free;
  logic [7:0]        emit_b;
  logic [4:0]        dv;
  logic [hts_pkg::NUM_W-1:0] nv;
  logic              digit_bad;
  logic [1:0]        utf_lm1;

  assign h          = lab_r[0];
  assign rem        = count_r - CNT_W'(1);
  assign depth_zero = (depth_r == '0);

  // pattern matches around the head byte
  always_comb begin
    m_cm = (rem >= CNT_W'(3)) && (lab_r[1] == hts_pkg::CH_BANG) &&
           (lab_r[2] == hts_pkg::CH_DASH) && (lab_r[3] == hts_pkg::CH_DASH);
    m_sc = (rem >= CNT_W'(7)) &&
           (hts_pkg::is_ws(lab_r[7]) || (lab_r[7] == hts_pkg::CH_GT));
    for (int j = 0; j < 6; j++) begin
      if (hts_pkg::fold(lab_r[j+1]) != hts_pkg::PAT_SCRIPT[8*(5-j) +: 8]) m_sc = 1'b0;
    end
    m_st = (rem >= CNT_W'(6)) &&
           (hts_pkg::is_ws(lab_r[6]) || (lab_r[6] == hts_pkg::CH_GT));
    for (int j = 0; j < 5; j++) begin
      if (hts_pkg::fold(lab_r[j+1]) != hts_pkg::PAT_STYLE[8*(4-j) +: 8]) m_st = 1'b0;
    end
    m_cd = (rem >= CNT_W'(8));
    for (int j = 0; j < 8; j++) begin
      if (hts_pkg::fold(lab_r[j+1]) != hts_pkg::PAT_CDATA[8*(7-j) +: 8]) m_cd = 1'b0;
    end
    m_bo = sq_r && (rem >= CNT_W'(11)) &&
           (hts_pkg::is_ws(lab_r[11]) || (lab_r[11] == hts_pkg::CH_GT));
    for (int j = 0; j < 10; j++) begin
      if (hts_pkg::fold(lab_r[j+1]) != hts_pkg::PAT_BQ[8*(9-j) +: 8]) m_bo = 1'b0;
    end
    m_bc = sq_r && !depth_zero && (rem >= CNT_W'(12));
    for (int j = 0; j < 12; j++) begin
      if (hts_pkg::fold(lab_r[j+1]) != hts_pkg::PAT_BQ_END[8*(11-j) +: 8]) m_bc = 1'b0;
    end
    t_found = 1'b0;
    for (int j = 0; j < 12; j++) begin
      if ((CNT_W'(j) < rem) &&
          (hts_pkg::is_ws(lab_r[j+1]) || (lab_r[j+1] == hts_pkg::CH_GT))) t_found = 1'b1;
    end
    e_sc_ok = 1'b1;
    for (int j = 0; j < 9; j++) begin
      if ((CNT_W'(j) < count_r) &&
          (hts_pkg::fold(lab_r[j]) != hts_pkg::PAT_SCRIPT_END[8*(8-j) +: 8])) e_sc_ok = 1'b0;
    end
    e_st_ok = 1'b1;
    for (int j = 0; j < 8; j++) begin
      if ((CNT_W'(j) < count_r) &&
          (hts_pkg::fold(lab_r[j]) != hts_pkg::PAT_STYLE_END[8*(7-j) +: 8])) e_st_ok = 1'b0;
    end
    e_cd_ok = 1'b1;
    for (int j = 0; j < 3; j++) begin
      if ((CNT_W'(j) < count_r) &&
          (lab_r[j] != hts_pkg::PAT_CDATA_END[8*(2-j) +: 8])) e_cd_ok = 1'b0;
    end
  end

  // entity terminator search
  always_comb begin
    n_hit = 1'b0;
    n_ws  = 1'b0;
    n_f   = '0;
    for (int k = 0; k < ELIM; k++) begin
      if (!n_hit && (CNT_W'(k) < rem) &&
          (hts_pkg::is_ws(lab_r[k+1]) || (lab_r[k+1] == hts_pkg::CH_SEMI))) begin
        n_hit = 1'b1;
        n_ws  = hts_pkg::is_ws(lab_r[k+1]);
        n_f   = SW'(k);
      end
    end
    n_hex  = (lab_r[2] == hts_pkg::CH_X);
    n_num  = n_hit && !n_ws && (n_f >= SW'(2)) && (lab_r[1] == hts_pkg::CH_HASH);
    n_bad0 = (n_f == (n_hex ? SW'(2) : SW'(1)));
  end

  // head decision
  always_comb begin
    dec_undec = 1'b0;
    dec_adv   = SW'(1);
    dec_mode  = mode_r;
    dec_emit  = 1'b0;
    dec_space = 1'b0;
    dec_inc   = 1'b0;
    dec_dec   = 1'b0;
    dec_ent   = 1'b0;
    case (mode_r)
      hts_pkg::MODE_TEXT: begin
        if (h == hts_pkg::CH_LT) begin
          if (m_cm) begin
            dec_mode = hts_pkg::MODE_COMMENT;
            dec_adv  = SW'(4);
          end else if (m_sc) begin
            dec_mode = hts_pkg::MODE_SCRIPT;
            dec_adv  = SW'(8);
          end else if (m_st) begin
            dec_mode = hts_pkg::MODE_STYLE;
            dec_adv  = SW'(7);
          end else if (m_cd) begin
            dec_mode = hts_pkg::MODE_CDATA;
            dec_adv  = SW'(9);
          end else if (m_bo) begin
            dec_inc  = 1'b1;
            dec_mode = hts_pkg::MODE_TAG;
          end else if (m_bc) begin
            dec_dec  = 1'b1;
            dec_mode = hts_pkg::MODE_TAG;
          end else if ((rem < CNT_W'(12)) && !t_found) begin
            dec_undec = 1'b1;
          end else begin
            dec_mode = hts_pkg::MODE_TAG;
          end
        end else if (depth_zero) begin
          if (h == hts_pkg::CH_AMP) begin
            if (n_hit) begin
              if (!n_ws) begin
                dec_adv = n_f + SW'(2);
                dec_ent = n_num;
              end
            end else if (rem <= CNT_W'(ELIM)) begin
              dec_undec = 1'b1;
            end
          end else begin
            dec_emit = 1'b1;
          end
        end
      end
      hts_pkg::MODE_TAG: begin
        if (h == hts_pkg::CH_DQ) begin
          dec_mode = hts_pkg::MODE_TAG_DQ;
        end else if (h == hts_pkg::CH_SQ) begin
          dec_mode = hts_pkg::MODE_TAG_SQ;
        end else if (h == hts_pkg::CH_GT) begin
          dec_mode  = hts_pkg::MODE_TEXT;
          dec_space = 1'b1;
        end
      end
      hts_pkg::MODE_TAG_DQ: begin
        if (h == hts_pkg::CH_DQ) begin
          dec_mode = hts_pkg::MODE_TAG;
        end else if (h == hts_pkg::CH_BSL) begin
          dec_mode = hts_pkg::MODE_TAG_DQ_ESC;
        end
      end
      hts_pkg::MODE_TAG_DQ_ESC: dec_mode = hts_pkg::MODE_TAG_DQ;
      hts_pkg::MODE_TAG_SQ: begin
        if (h == hts_pkg::CH_SQ) begin
          dec_mode = hts_pkg::MODE_TAG;
        end else if (h == hts_pkg::CH_BSL) begin
          dec_mode = hts_pkg::MODE_TAG_SQ_ESC;
        end
      end
      hts_pkg::MODE_TAG_SQ_ESC: dec_mode = hts_pkg::MODE_TAG_SQ;
      hts_pkg::MODE_COMMENT: begin
        if (h == hts_pkg::CH_DASH) begin
          if (rem == '0) begin
            dec_undec = 1'b1;
          end else if (lab_r[1] == hts_pkg::CH_DASH) begin
            dec_mode = hts_pkg::MODE_COMMENT_END;
            dec_adv  = SW'(2);
          end
        end
      end
      hts_pkg::MODE_COMMENT_END: begin
        if (h == hts_pkg::CH_GT) begin
          dec_mode = hts_pkg::MODE_TEXT;
        end else if (!hts_pkg::is_ws(h)) begin
          dec_mode = hts_pkg::MODE_COMMENT;
        end
      end
      hts_pkg::MODE_SCRIPT: begin
        if ((h == hts_pkg::CH_LT) && e_sc_ok) begin
          if (count_r < CNT_W'(9)) begin
            dec_undec = 1'b1;
          end else begin
            dec_space = 1'b1;
            dec_mode  = hts_pkg::MODE_TEXT;
            dec_adv   = SW'(9);
          end
        end
      end
      hts_pkg::MODE_STYLE: begin
        if ((h == hts_pkg::CH_LT) && e_st_ok) begin
          if (count_r < CNT_W'(8)) begin
            dec_undec = 1'b1;
          end else begin
            dec_space = 1'b1;
            dec_mode  = hts_pkg::MODE_TEXT;
            dec_adv   = SW'(8);
          end
        end
      end
      hts_pkg::MODE_CDATA: begin
        if ((h == hts_pkg::CH_RBR) && e_cd_ok) begin
          if (count_r < CNT_W'(3)) begin
            dec_undec = 1'b1;
          end else begin
            dec_mode = hts_pkg::MODE_TEXT;
            dec_adv  = SW'(3);
          end
        end else begin
          dec_emit = depth_zero;
        end
      end
      default: dec_mode = hts_pkg::MODE_TEXT;
    endcase
  end

  // entity digit and encoder
  always_comb begin
    dv = hts_pkg::digit_val(h, ent_hex_r);
    if (ent_hex_r) begin
      nv = {ent_val_r, 4'b0000} + hts_pkg::NUM_W'(dv[3:0]);
    end else begin
      nv = ({4'b0000, ent_val_r} << 3) + ({4'b0000, ent_val_r} << 1) +
           hts_pkg::NUM_W'(dv[3:0]);
    end
    digit_bad = !dv[4] || (nv > hts_pkg::CP_MAX);
    utf_lm1   = hts_pkg::utf8_len(ent_val_r);
  end

  assign out_free  = !out_v_r || out_ready;
  assign space_ok  = any_r && (last_r != hts_pkg::CH_SP) && (last_r != hts_pkg::CH_NL);
  assign emit_req  = dec_emit || (dec_space && space_ok);
  assign emit_b    = cmd.utf ? hts_pkg::utf8_byte(ent_val_r, utf_lm1, utf_idx_r) :
                     (dec_space ? hts_pkg::CH_SP : h);
  assign emit_fire = (cmd.decide && emit_req) || cmd.utf;
  assign store_ok  = res_cnt_r < hts_pkg::RES_CNT_W'(hts_pkg::MAX_RESULTS);
  assign do_shift  = cmd.decide || cmd.drop || cmd.skip || cmd.ent;

  always_comb begin
    sts.empty     = (count_r == '0);
    sts.one       = (count_r == CNT_W'(1));
    sts.full      = (count_r == CNT_W'(DEPTH + 1));
    sts.undecided = dec_undec;
    sts.more      = (dec_adv != SW'(1));
    sts.ent_num   = dec_ent;
    sts.can_emit  = !hold_v_r || out_free;
    sts.hold_pend = hold_v_r;
    sts.out_free  = out_free;
    sts.skip_last = (skip_r == SW'(1));
    sts.ent_good  = !ent_bad_r && !((ent_val_r >= hts_pkg::SUR_LO) &&
                                    (ent_val_r <= hts_pkg::SUR_HI));
    sts.utf_last  = (utf_idx_r == utf_lm1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      mode_r    <= hts_pkg::MODE_TEXT;
      depth_r   <= '0;
      last_r    <= '0;
      any_r     <= 1'b0;
      sq_r      <= 1'b0;
      hold_v_r  <= 1'b0;
      res_cnt_r <= '0;
      out_v_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        sq_r <= cfg_wdata;
      end
      if (cmd.accept) begin
        count_r   <= count_r + CNT_W'(1);
        res_cnt_r <= '0;
      end else if (do_shift) begin
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.decide) begin
        mode_r <= dec_mode;
        if (dec_inc && (depth_r != '1)) begin
          depth_r <= depth_r + QDB'(1);
        end
        if (dec_dec) begin
          depth_r <= depth_r - QDB'(1);
        end
      end
      if (hold_v_r && ((emit_fire && store_ok) || cmd.flush)) begin
        out_v_r <= 1'b1;
      end else if (out_v_r && out_ready) begin
        out_v_r <= 1'b0;
      end
      if (emit_fire) begin
        last_r <= emit_b;
        any_r  <= 1'b1;
        if (store_ok) begin
          hold_v_r  <= 1'b1;
          res_cnt_r <= res_cnt_r + hts_pkg::RES_CNT_W'(1);
        end
      end
      if (cmd.flush && hold_v_r) begin
        hold_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j <= DEPTH; j++) begin
      if (do_shift) begin
        if (j < DEPTH) begin
          lab_r[j] <= lab_r[j+1];
        end
      end else if (cmd.accept && (count_r == CNT_W'(j))) begin
        lab_r[j] <= in_byte;
      end
    end
    if (cmd.decide) begin
      skip_r    <= dec_adv - SW'(1);
      ent_val_r <= '0;
      ent_hex_r <= n_hex;
      ent_pre_r <= n_hex ? 2'd2 : 2'd1;
      ent_bad_r <= n_bad0;
    end
    if (cmd.skip || cmd.ent) begin
      skip_r <= skip_r - SW'(1);
    end
    if (cmd.ent) begin
      if (ent_pre_r != 2'd0) begin
        ent_pre_r <= ent_pre_r - 2'd1;
      end else if ((skip_r != SW'(1)) && !ent_bad_r) begin
        if (digit_bad) begin
          ent_bad_r <= 1'b1;
        end else begin
          ent_val_r <= nv[hts_pkg::CP_W-1:0];
        end
      end
      utf_idx_r <= 2'd0;
    end
    if (cmd.utf) begin
      utf_idx_r <= utf_idx_r + 2'd1;
    end
    if (emit_fire && store_ok) begin
      if (hold_v_r) begin
        out_b_r <= hold_b_r;
        out_l_r <= 1'b0;
      end
      hold_b_r <= emit_b;
    end
    if (cmd.flush && hold_v_r) begin
      out_b_r <= hold_b_r;
      out_l_r <= 1'b1;
    end
  end

  assign out_valid = out_v_r;
  assign out_byte  = out_b_r;
  assign out_last  = out_l_r;

endmodule

`default_nettype wire

[sv/html_to_text_stripper_core.sv]
// Top level of the HTML to plain-text stripper.
//
//   channel  | dir | handshake     | payload
//   in_if    | in  | valid/ready   | in_byte[7:0]
//   out_if   | out | valid/ready   | out_byte[7:0], out_last
//   cfg      | in  | cfg_we        | cfg_wdata (skip_quoted)
//
// A byte that settles at once is first loaded into the lookahead register and then
// decided. Further bytes consumed from the lookahead (tag openers, end markers,
// entities, replays) are handled one after another, and so is each UTF-8 byte.
// The last result of a step is held back one slot and released with out_last set.
// Reset is synchronous and clears the state machine, counters, parse mode and valid flags.
// Once two results wait on a stalled result channel, every decision and every UTF-8
// byte holds; input waits meanwhile.
`default_nettype none

module html_to_text_stripper_core #(
  parameter int LOOKAHEAD_DEPTH  = 16,
  parameter int ENTITY_MAX_LEN   = 10,
  parameter int QUOTE_DEPTH_BITS = 8
) (
  input wire logic  clk,
  input wire logic  rst_n,
  hts_in_if.sink    in_if,
  hts_out_if.source out_if,
  input wire logic  cfg_we,
  input wire logic  cfg_wdata
);

  hts_pkg::cmd_t cmd;
  hts_pkg::sts_t sts;

  hts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  hts_dp #(
    .DEPTH (LOOKAHEAD_DEPTH),
    .EML   (ENTITY_MAX_LEN),
    .QDB   (QUOTE_DEPTH_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_byte   (in_if.in_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_ready (out_if.ready),
    .out_valid (out_if.valid),
    .out_byte  (out_if.out_byte),
    .out_last  (out_if.out_last)
  );

endmodule

`default_nettype wire

[sv/hts_chk.sv]
// Port checker of the stripper and its binding to the top level.
`default_nettype none

module hts_chk (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(out_last))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item taken before previous item decided");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

endmodule

bind html_to_text_stripper_core hts_chk u_hts_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_byte  (out_if.out_byte),
  .out_last  (out_if.out_last)
);

`default_nettype wire
